### rtl/core/mpbf_pkg.sv
// Shared operation codes, status codes and field widths for the byte pipe table.
package mpbf_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int TDATA_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC        = 3'd0,
    OP_READ         = 3'd1,
    OP_WRITE        = 3'd2,
    OP_ADD_READER   = 3'd3,
    OP_ADD_WRITER   = 3'd4,
    OP_DROP_READER  = 3'd5,
    OP_DROP_WRITER  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INACTIVE  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_EOF       = 3'd3,
    ST_FULL      = 3'd4,
    ST_BROKEN    = 3'd5,
    ST_NONE_FREE = 3'd6
  } status_t;

endpackage

### rtl/core/mpbf_byte_store.sv
// Byte storage for all pipes: one synchronous memory, one access per cycle.
module mpbf_byte_store #(
  parameter int NUM_PIPES = 8,
  parameter int BUF_SIZE  = 512,
  parameter int IW        = 3,
  parameter int PW        = 9
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic                       wr_en,
  input  logic [IW-1:0]              pipe_idx,
  input  logic [PW-1:0]              ptr,
  input  logic [mpbf_pkg::BYTE_W-1:0] wdata,
  output logic [mpbf_pkg::BYTE_W-1:0] rdata
);

  localparam int DEPTH = NUM_PIPES * BUF_SIZE;
  localparam int AW    = $clog2(DEPTH);

  logic [mpbf_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]               addr;

  // Each pipe owns a contiguous slice of BUF_SIZE bytes.
  assign addr = AW'(pipe_idx) * AW'(BUF_SIZE) + AW'(ptr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/mpbf_desc_table.sv
// Per-pipe descriptor memory (pointers and counts) plus the active flags.
module mpbf_desc_table #(
  parameter int NUM_PIPES = 8,
  parameter int IW        = 3,
  parameter int DW        = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  output logic [DW-1:0] rd_desc,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic [DW-1:0] wr_desc,
  input  logic          set_in_use,
  input  logic [IW-1:0] chk_idx,
  output logic          chk_in_use,
  output logic          free_found,
  output logic [IW-1:0] free_idx
);

  logic [DW-1:0]        mem [NUM_PIPES];
  logic [NUM_PIPES-1:0] in_use;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_desc;
    end
    if (rd_en) begin
      rd_desc <= mem[rd_idx];
    end
  end

  // Descriptor contents are only trusted for pipes that are flagged active.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (set_in_use) begin
      in_use[wr_idx] <= 1'b1;
    end
  end

  assign chk_in_use = in_use[chk_idx];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

endmodule

### rtl/core/multi_pipe_byte_fifo_table_core.sv
// Top level of the byte pipe table: request sequencer around the two memories.
//
// Usage: one request enters on the s_ channel, one response leaves on the m_
// channel. A request carries an operation (allocate, read byte, write byte,
// add or drop a reader or writer reference), a pipe index and a data byte.
// Every request produces exactly one response, in request order.
// Sequence: after acceptance a request moves to S_LOOK, where its registered
// descriptor read is decided; a successful byte read then passes S_BYTE, where
// the registered byte memory read returns; S_DONE loads the response register.
// Requests are processed one at a time (s_tready is high only in S_IDLE), as
// set by the descriptor read-modify-write.
// The response register decouples the sides: a new request is accepted while
// an older response still waits on m_tready; a finished request then waits
// for the response register to drain before the next one is taken.
// Reset clears the sequencer, the response valid and every pipe's active
// flag; pipe descriptors and bytes are initialized by allocation and writes.
module multi_pipe_byte_fifo_table_core #(
  parameter int NUM_PIPES = 8,
  parameter int BUF_SIZE  = 512
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // operation[2:0], pipe_id[5:3], write_data[13:6], zero fill[15:14]
  input  logic [mpbf_pkg::TDATA_W-1:0]     s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[2:0], read_data[10:3], granted_pipe[13:11], wake_readers[14],
  // wake_writers[15]
  output logic [mpbf_pkg::TDATA_W-1:0]     m_tdata
);

  localparam int PW = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;
  localparam int IW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int CW = mpbf_pkg::COUNT_W;
  localparam int DW = 2 * CW + 2 * PW;

  typedef struct packed {
    logic [CW-1:0] rcount;
    logic [CW-1:0] wcount;
    logic [PW-1:0] rptr;
    logic [PW-1:0] wptr;
  } desc_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_BYTE,
    S_DONE
  } state_t;

  state_t                          state;
  logic [mpbf_pkg::OP_W-1:0]       op;
  logic [mpbf_pkg::ID_W-1:0]       pid;
  logic [mpbf_pkg::BYTE_W-1:0]     wdata;
  mpbf_pkg::status_t               res_status;
  logic [mpbf_pkg::BYTE_W-1:0]     res_rdata;
  logic [mpbf_pkg::ID_W-1:0]       res_grant;
  logic                            res_wr;
  logic                            res_ww;

  logic                            accept;
  logic [DW-1:0]                   rd_word;
  desc_t                           d_cur;
  desc_t                           d_new;
  logic                            in_use_bit;
  logic                            free_found;
  logic [IW-1:0]                   free_idx;
  logic [IW-1:0]                   idx;
  logic [IW-1:0]                   wr_idx;
  logic                            desc_we;
  logic                            set_in_use;
  logic                            id_ok;
  logic                            b_rd;
  logic                            b_wr;
  logic [PW-1:0]                   b_ptr;
  logic [mpbf_pkg::BYTE_W-1:0]     b_rdata;
  mpbf_pkg::status_t               st;
  logic [mpbf_pkg::ID_W-1:0]       grant;
  logic                            wr_flag;
  logic                            ww_flag;
  logic [CW-1:0]                   cnt_dec;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == PW'(BUF_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx      = IW'(pid);
  assign d_cur    = desc_t'(rd_word);

  mpbf_desc_table #(
    .NUM_PIPES (NUM_PIPES),
    .IW        (IW),
    .DW        (DW)
  ) u_desc (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_idx     (IW'(s_tdata[5:3])),
    .rd_desc    (rd_word),
    .wr_en      (desc_we),
    .wr_idx     (wr_idx),
    .wr_desc    (DW'(d_new)),
    .set_in_use (set_in_use),
    .chk_idx    (idx),
    .chk_in_use (in_use_bit),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  mpbf_byte_store #(
    .NUM_PIPES (NUM_PIPES),
    .BUF_SIZE  (BUF_SIZE),
    .IW        (IW),
    .PW        (PW)
  ) u_bytes (
    .clk      (clk),
    .rd_en    (b_rd),
    .wr_en    (b_wr),
    .pipe_idx (idx),
    .ptr      (b_ptr),
    .wdata    (wdata),
    .rdata    (b_rdata)
  );

  // Decide the request in the cycle its descriptor arrives from memory.
  always_comb begin
    d_new      = d_cur;
    desc_we    = 1'b0;
    set_in_use = 1'b0;
    wr_idx     = idx;
    st         = mpbf_pkg::ST_OK;
    grant      = '0;
    wr_flag    = 1'b0;
    ww_flag    = 1'b0;
    b_rd       = 1'b0;
    b_wr       = 1'b0;
    b_ptr      = d_cur.wptr;
    cnt_dec    = '0;
    id_ok      = (int'(pid) < NUM_PIPES) && in_use_bit;
    if (state == S_LOOK) begin
      if (op == mpbf_pkg::OP_ALLOC) begin
        if (free_found) begin
          set_in_use = 1'b1;
          desc_we    = 1'b1;
          wr_idx     = free_idx;
          d_new      = '{rcount: CW'(1), wcount: CW'(1), rptr: '0, wptr: '0};
          grant      = mpbf_pkg::ID_W'(free_idx);
        end else begin
          st = mpbf_pkg::ST_NONE_FREE;
        end
      end else if (op <= mpbf_pkg::OP_DROP_WRITER) begin
        if (!id_ok) begin
          st = mpbf_pkg::ST_INACTIVE;
        end else begin
          case (op)
            mpbf_pkg::OP_READ: begin
              if (d_cur.wptr == d_cur.rptr) begin
                st = (d_cur.wcount == '0) ? mpbf_pkg::ST_EOF : mpbf_pkg::ST_EMPTY;
              end else begin
                b_rd       = 1'b1;
                b_ptr      = d_cur.rptr;
                d_new.rptr = adv(d_cur.rptr);
                desc_we    = 1'b1;
                ww_flag    = 1'b1;
              end
            end
            mpbf_pkg::OP_WRITE: begin
              if (d_cur.rcount == '0) begin
                st = mpbf_pkg::ST_BROKEN;
              end else if (adv(d_cur.wptr) == d_cur.rptr) begin
                st      = mpbf_pkg::ST_FULL;
                wr_flag = 1'b1;
              end else begin
                b_wr       = 1'b1;
                d_new.wptr = adv(d_cur.wptr);
                desc_we    = 1'b1;
                wr_flag    = 1'b1;
              end
            end
            mpbf_pkg::OP_ADD_READER: begin
              if (d_cur.rcount != '1) begin
                d_new.rcount = d_cur.rcount + 1'b1;
              end
              desc_we = 1'b1;
            end
            mpbf_pkg::OP_ADD_WRITER: begin
              if (d_cur.wcount != '1) begin
                d_new.wcount = d_cur.wcount + 1'b1;
              end
              desc_we = 1'b1;
            end
            mpbf_pkg::OP_DROP_READER: begin
              cnt_dec      = (d_cur.rcount != '0) ? d_cur.rcount - 1'b1 : '0;
              d_new.rcount = cnt_dec;
              ww_flag      = (cnt_dec == '0);
              desc_we      = 1'b1;
            end
            mpbf_pkg::OP_DROP_WRITER: begin
              cnt_dec      = (d_cur.wcount != '0) ? d_cur.wcount - 1'b1 : '0;
              d_new.wcount = cnt_dec;
              wr_flag      = (cnt_dec == '0);
              desc_we      = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // In S_DONE the load below decides the valid bit on its own.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= s_tdata[2:0];
            pid   <= s_tdata[5:3];
            wdata <= s_tdata[13:6];
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_status <= st;
          res_rdata  <= '0;
          res_grant  <= grant;
          res_wr     <= wr_flag;
          res_ww     <= ww_flag;
          state      <= b_rd ? S_BYTE : S_DONE;
        end
        S_BYTE: begin
          res_rdata <= b_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_ww, res_wr, res_grant, res_rdata, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOK)
    else $error("accepted request did not move to descriptor lookup");

  a_byte_read_next: assert property (@(posedge clk) disable iff (rst)
    b_rd |=> state == S_BYTE)
    else $error("byte read issued without waiting for its data");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> m_tvalid && state == S_IDLE)
    else $error("finished response was not loaded into the output register");

  a_one_byte_access: assert property (@(posedge clk) disable iff (rst)
    (b_rd || b_wr) |-> (state == S_LOOK && id_ok))
    else $error("byte memory accessed for an inactive pipe or outside lookup");

endmodule
